// File: hw/rtl/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared constants, request codes and the queue status type of the Huffman
// code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

	localparam int MAX_CODE_LEN = 32;
	localparam int NUM_SYMBOLS  = 256;

	localparam int CODE_W   = 32;
	localparam int SYM_W    = 8;
	localparam int REQ_W    = 2;
	localparam int CLEN_W   = 6;
	localparam int BYTE_W   = 8;
	localparam int USED_W   = 4;
	localparam int PCNT_W   = 3;

	localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ENCODE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_FLUSH  = 2'd2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef struct packed {
		logic              not_empty;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

endpackage

// File: hw/rtl/huffman_code_bit_packer.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Byte-wise Huffman encoder: code table lookup in front, bit packing behind
// a four-entry queue.
// ----------------------------------------------------------------------------
// path: a request passes the table lookup register and the queue before it
// reaches the packer; its bytes leave through the output register
// throughput: one request accepted per cycle while the queue has room; the
// packer consumes up to eight code bits a cycle while the output is not
// stalled; encodes and flushes are queued for the packer, loads never reach it
// reset: table entries read as empty codes via per-symbol valid bits, no
// clearing pass; pending byte cleared
module huffman_code_bit_packer #(
	parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN,
	parameter int NUM_SYMBOLS  = hcbp_pkg::NUM_SYMBOLS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [hcbp_pkg::REQ_W-1:0]    req_type,
	input  logic [hcbp_pkg::SYM_W-1:0]    symbol,
	input  logic [hcbp_pkg::CODE_W-1:0]   code_value,
	input  logic [hcbp_pkg::CLEN_W-1:0]   code_length,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [hcbp_pkg::BYTE_W-1:0]   out_byte,
	output logic [hcbp_pkg::USED_W-1:0]   bits_used,
	output logic                          out_last
);

	localparam int LW = $clog2(MAX_CODE_LEN + 1);
	localparam int SW = (MAX_CODE_LEN > hcbp_pkg::CODE_W) ? MAX_CODE_LEN : hcbp_pkg::CODE_W;
	localparam int DW = 1 + SW + LW;

	logic              push;
	logic [DW-1:0]     push_data;
	logic              pop;
	logic [DW-1:0]     head_data;
	hcbp_pkg::q_stat_t q_stat;

	hcbp_front #(
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.NUM_SYMBOLS  (NUM_SYMBOLS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.symbol      (symbol),
		.code_value  (code_value),
		.code_length (code_length),
		.q_stat      (q_stat),
		.push        (push),
		.push_data   (push_data)
	);

	hcbp_queue #(
		.DW (DW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head_data (head_data),
		.q_stat    (q_stat)
	);

	hcbp_back #(
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_data (head_data),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.bits_used (bits_used),
		.out_last  (out_last)
	);

endmodule

// File: hw/rtl/hcbp_ram.sv
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/hcbp_front.sv
// ----------------------------------------------------------------------------
// hcbp_front
// Accepts requests, writes code table entries, looks up codes for encode
// requests and pushes left-aligned codes and flushes into the queue.
// ----------------------------------------------------------------------------
module hcbp_front #(
	parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN,
	parameter int NUM_SYMBOLS  = hcbp_pkg::NUM_SYMBOLS,
	localparam int LW  = $clog2(MAX_CODE_LEN + 1),
	localparam int SW  = (MAX_CODE_LEN > hcbp_pkg::CODE_W) ? MAX_CODE_LEN : hcbp_pkg::CODE_W,
	localparam int DW  = 1 + SW + LW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [hcbp_pkg::REQ_W-1:0]    req_type,
	input  logic [hcbp_pkg::SYM_W-1:0]    symbol,
	input  logic [hcbp_pkg::CODE_W-1:0]   code_value,
	input  logic [hcbp_pkg::CLEN_W-1:0]   code_length,
	input  hcbp_pkg::q_stat_t             q_stat,
	output logic                          push,
	output logic [DW-1:0]                 push_data
);

	localparam int AW  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
	localparam int EW  = hcbp_pkg::CODE_W + LW;
	localparam int SHW = $clog2(SW + 1);
	localparam int CW  = hcbp_pkg::QCNT_W + 1;

	logic                   accept;
	logic                   in_range;
	logic [AW-1:0]          addr;
	logic [LW-1:0]          clamp_len;
	logic                   we;
	logic [EW-1:0]          rdata;
	logic [NUM_SYMBOLS-1:0] valid_q;
	logic                   v_s1;
	logic                   flush_s1;
	logic                   hit_s1;
	logic [LW-1:0]          ent_len;
	logic [hcbp_pkg::CODE_W-1:0] ent_val;
	logic [SW-1:0]          aligned;
	logic [SHW-1:0]         shamt;

	assign in_ready = ({1'b0, q_stat.count} + CW'(v_s1)) < CW'(hcbp_pkg::QUEUE_DEPTH);
	assign accept   = in_valid && in_ready;
	assign in_range = {1'b0, symbol} < (hcbp_pkg::SYM_W + 1)'(NUM_SYMBOLS);
	assign addr     = symbol[AW-1:0];
	assign clamp_len = (code_length > hcbp_pkg::CLEN_W'(MAX_CODE_LEN)) ?
		LW'(MAX_CODE_LEN) : code_length[LW-1:0];
	assign we       = accept && (req_type == hcbp_pkg::REQ_LOAD) && in_range;

	hcbp_ram #(
		.WIDTH (EW),
		.DEPTH (NUM_SYMBOLS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (addr),
		.wdata ({code_value, clamp_len}),
		.raddr (addr),
		.rdata (rdata)
	);

	// entries never loaded read as empty codes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			v_s1     <= 1'b0;
			flush_s1 <= 1'b0;
			hit_s1   <= 1'b0;
		end else begin
			if (we) begin
				valid_q[addr] <= 1'b1;
			end
			v_s1     <= accept && ((req_type == hcbp_pkg::REQ_ENCODE) ||
				(req_type == hcbp_pkg::REQ_FLUSH));
			flush_s1 <= req_type == hcbp_pkg::REQ_FLUSH;
			hit_s1   <= in_range && valid_q[addr];
		end
	end

	assign ent_len = hit_s1 ? rdata[LW-1:0] : '0;
	assign ent_val = rdata[EW-1:LW];
	assign shamt   = SHW'(SW) - SHW'(ent_len);
	assign aligned = SW'(ent_val) << shamt;

	// empty codes produce nothing and are dropped here
	assign push      = v_s1 && (flush_s1 || (ent_len != '0));
	assign push_data = {flush_s1, aligned, ent_len};

endmodule

// File: hw/rtl/hcbp_queue.sv
// ----------------------------------------------------------------------------
// hcbp_queue
// Short FIFO between the lookup front and the bit packing back.
// ----------------------------------------------------------------------------
module hcbp_queue #(
	parameter int DW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DW-1:0]     push_data,
	input  logic              pop,
	output logic [DW-1:0]     head_data,
	output hcbp_pkg::q_stat_t q_stat
);

	logic [DW-1:0]                 mem_q [hcbp_pkg::QUEUE_DEPTH];
	logic [hcbp_pkg::QPTR_W-1:0]   wptr_q;
	logic [hcbp_pkg::QPTR_W-1:0]   rptr_q;
	logic [hcbp_pkg::QCNT_W-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head_data        = mem_q[rptr_q];
	assign q_stat.not_empty = count_q != '0;
	assign q_stat.count     = count_q;

endmodule

// File: hw/rtl/hcbp_back.sv
// ----------------------------------------------------------------------------
// hcbp_back
// Packs queued codes into bytes, up to eight bits a cycle while the output is
// not stalled, and holds the output register.
// ----------------------------------------------------------------------------
module hcbp_back #(
	parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN,
	localparam int LW  = $clog2(MAX_CODE_LEN + 1),
	localparam int SW  = (MAX_CODE_LEN > hcbp_pkg::CODE_W) ? MAX_CODE_LEN : hcbp_pkg::CODE_W,
	localparam int DW  = 1 + SW + LW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [DW-1:0]                 head_data,
	input  hcbp_pkg::q_stat_t             q_stat,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [hcbp_pkg::BYTE_W-1:0]   out_byte,
	output logic [hcbp_pkg::USED_W-1:0]   bits_used,
	output logic                          out_last
);

	localparam int BW = hcbp_pkg::BYTE_W;
	localparam int UW = hcbp_pkg::USED_W;
	localparam int PW = hcbp_pkg::PCNT_W;

	logic          cur_valid_q;
	logic          cur_flush_q;
	logic [SW-1:0] sr_q;
	logic [LW-1:0] rem_q;
	logic [BW-1:0] pend_q;
	logic [PW-1:0] pcnt_q;
	logic          out_valid_q;

	logic          advance;
	logic [UW-1:0] space;
	logic [LW-1:0] k;
	logic [UW-1:0] cnt_sum;
	logic          full;
	logic [BW-1:0] combined;
	logic [LW-1:0] rem_left;
	logic          step;
	logic          done;
	logic          emit;
	logic          take;

	assign advance  = !out_valid_q || out_ready;
	assign step     = cur_valid_q && advance;
	assign space    = UW'(BW) - UW'(pcnt_q);
	assign k        = (rem_q < LW'(space)) ? rem_q : LW'(space);
	assign cnt_sum  = UW'(pcnt_q) + k[UW-1:0];
	assign full     = cnt_sum[UW-1];
	assign combined = pend_q | (sr_q[SW-1 -: BW] >> pcnt_q);
	assign rem_left = rem_q - k;
	assign done     = step && (cur_flush_q || (rem_left == '0));
	assign emit     = step && (cur_flush_q ? (pcnt_q != '0) : full);
	assign take     = q_stat.not_empty && (!cur_valid_q || done);
	assign pop      = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pend_q      <= '0;
			pcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				cur_valid_q <= 1'b1;
			end else if (done) begin
				cur_valid_q <= 1'b0;
			end
			if (step) begin
				if (cur_flush_q || full) begin
					pend_q <= '0;
					pcnt_q <= '0;
				end else begin
					pend_q <= combined;
					pcnt_q <= cnt_sum[PW-1:0];
				end
			end
			if (advance) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_flush_q <= head_data[DW-1];
			sr_q        <= head_data[DW-2:LW];
			rem_q       <= head_data[LW-1:0];
		end else if (step) begin
			sr_q  <= sr_q << k;
			rem_q <= rem_left;
		end
		if (emit) begin
			if (cur_flush_q) begin
				out_byte  <= pend_q;
				bits_used <= UW'(pcnt_q);
				out_last  <= 1'b1;
			end else begin
				out_byte  <= combined;
				bits_used <= UW'(BW);
				// fewer than eight bits left cannot fill another byte
				out_last  <= rem_left < LW'(BW);
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
